FILE: hdl/pctt_pkg.sv
// ----------------------------------------------------------------------------
// pctt_pkg: shared types and constants for the peer timeout table
// Field widths, command/event/status codes and the controller-datapath
// command and status structures.
// ----------------------------------------------------------------------------
package pctt_pkg;

    localparam int MAX_PEERS_DEF = 16;

    localparam int CMD_W        = 2;
    localparam int MAC_W        = 48;
    localparam int EV_W         = 2;
    localparam int TICK_W       = 20;
    localparam int STATUS_W     = 3;
    localparam int IDX_OUT_W    = 4;
    localparam int IN_TDATA_W   = 56;
    localparam int OUT_TDATA_W  = 56;
    localparam int OUT_TUSER_W  = STATUS_W;
    localparam int OUT_PAD_W    = OUT_TDATA_W - MAC_W - IDX_OUT_W;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 20'd60000;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_EVENT = 2'd2,
        CMD_TICK  = 2'd3
    } t_cmd;

    typedef enum logic [EV_W-1:0] {
        EV_PRIVATE_ACK  = 2'd0,
        EV_VLAN_ACK     = 2'd1,
        EV_BACKHAUL_ACK = 2'd2,
        EV_DISCONNECT   = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        LS_DISCONNECTED = 2'd0,
        LS_DETECTED     = 2'd1,
        LS_VLAN         = 2'd2,
        LS_CONNECTED    = 2'd3
    } t_link;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_TIMED_OUT = 3'd3,
        ST_TICK_DONE = 3'd4
    } t_status;

    // table update performed by the datapath
    typedef enum logic [2:0] {
        WR_NONE,
        WR_ADD,
        WR_CLEAR,
        WR_EVENT,
        WR_EXPIRE,
        WR_DEC
    } t_wr_op;

    // kind of result loaded into the output register
    typedef enum logic [2:0] {
        EM_ADD,
        EM_FULL,
        EM_CLEAR,
        EM_EVENT_OK,
        EM_NOT_FOUND,
        EM_TIMEOUT,
        EM_DONE
    } t_emit;

    typedef struct packed {
        logic   load;
        logic   idx_clr;
        logic   idx_inc;
        t_wr_op wr;
        logic   emit_en;
        t_emit  emit;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd command;
        logic full;
        logic hit;
        logic active;
        logic expire;
        logic last_idx;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: hdl/pctt_ctrl.sv
// ----------------------------------------------------------------------------
// pctt_ctrl: sequencing controller
// Accepts one item, dispatches on its command and walks the table one slot
// a cycle for events and ticks, stalling whenever the output register is
// occupied and a result is due.
// ----------------------------------------------------------------------------
module pctt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pctt_pkg::t_dp_stat i_stat,
    output pctt_pkg::t_dp_cmd  o_cmd
);
    import pctt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_FINAL
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.idx_clr   = 1'b0;
        o_cmd.idx_inc   = 1'b0;
        o_cmd.wr        = WR_NONE;
        o_cmd.emit_en   = 1'b0;
        o_cmd.emit      = EM_DONE;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                case (i_stat.command)
                    CMD_ADD: begin
                        if (i_stat.out_free) begin
                            o_cmd.emit_en = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.emit = EM_FULL;
                            end else begin
                                o_cmd.wr   = WR_ADD;
                                o_cmd.emit = EM_ADD;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    CMD_CLEAR: begin
                        if (i_stat.out_free) begin
                            o_cmd.wr      = WR_CLEAR;
                            o_cmd.emit_en = 1'b1;
                            o_cmd.emit    = EM_CLEAR;
                            n_state       = S_IDLE;
                        end
                    end
                    default: n_state = S_SCAN;
                endcase
            end

            S_SCAN: begin
                if (i_stat.command == CMD_EVENT) begin
                    if (i_stat.hit) begin
                        // first match wins: update it and finish
                        if (i_stat.out_free) begin
                            o_cmd.wr      = WR_EVENT;
                            o_cmd.emit_en = 1'b1;
                            o_cmd.emit    = EM_EVENT_OK;
                            n_state       = S_IDLE;
                        end
                    end else if (i_stat.last_idx) begin
                        n_state = S_FINAL;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                    end
                end else begin
                    if (i_stat.expire) begin
                        // hold on this slot until the timeout result can go out
                        if (i_stat.out_free) begin
                            o_cmd.wr      = WR_EXPIRE;
                            o_cmd.emit_en = 1'b1;
                            o_cmd.emit    = EM_TIMEOUT;
                            if (i_stat.last_idx) begin
                                n_state = S_FINAL;
                            end else begin
                                o_cmd.idx_inc = 1'b1;
                            end
                        end
                    end else begin
                        if (i_stat.active) begin
                            o_cmd.wr = WR_DEC;
                        end
                        if (i_stat.last_idx) begin
                            n_state = S_FINAL;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                        end
                    end
                end
            end

            S_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_en = 1'b1;
                    o_cmd.emit    = (i_stat.command == CMD_EVENT) ? EM_NOT_FOUND : EM_DONE;
                    n_state       = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hdl/pctt_dp.sv
// ----------------------------------------------------------------------------
// pctt_dp: peer table datapath
// Holds the timeout register, the captured item, the peer table, the scan
// index and the output register; performs the updates the controller asks for.
// ----------------------------------------------------------------------------
module pctt_dp #(
    parameter int MAX_PEERS = pctt_pkg::MAX_PEERS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wen,
    input  logic [pctt_pkg::TICK_W-1:0]    i_cfg_wdata,
    input  logic [pctt_pkg::CMD_W-1:0]     i_command,
    input  logic [pctt_pkg::MAC_W-1:0]     i_mac,
    input  logic [pctt_pkg::EV_W-1:0]      i_event_code,
    input  pctt_pkg::t_dp_cmd              i_cmd,
    output pctt_pkg::t_dp_stat             o_stat,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [pctt_pkg::STATUS_W-1:0]  o_status,
    output logic [pctt_pkg::MAC_W-1:0]     o_peer_mac,
    output logic [pctt_pkg::IDX_OUT_W-1:0] o_entry_index,
    output logic                           o_last
);
    import pctt_pkg::*;

    localparam int IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
    localparam int CNT_W = $clog2(MAX_PEERS + 1);

    logic [TICK_W-1:0]    r_timeout;
    t_cmd                 r_command;
    logic [MAC_W-1:0]     r_mac;
    t_event               r_event;
    logic [IDX_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_count;
    logic [MAX_PEERS-1:0] r_valid;
    logic [MAC_W-1:0]     r_addr  [MAX_PEERS];
    t_link                r_link  [MAX_PEERS];
    logic [TICK_W-1:0]    r_ticks [MAX_PEERS];

    logic                 r_out_valid;
    t_status              r_status;
    logic [MAC_W-1:0]     r_peer_mac;
    logic [IDX_OUT_W-1:0] r_entry_index;
    logic                 r_last;

    t_status              n_status;
    logic [MAC_W-1:0]     n_peer_mac;
    logic [IDX_OUT_W-1:0] n_entry_index;
    logic                 n_last;

    logic [MAC_W-1:0]     cur_addr;
    t_link                cur_link;
    logic [TICK_W-1:0]    cur_ticks;
    logic [IDX_W-1:0]     add_slot;
    logic                 cur_active;
    logic                 out_free;

    assign cur_addr   = r_addr[r_idx];
    assign cur_link   = r_link[r_idx];
    assign cur_ticks  = r_ticks[r_idx];
    assign add_slot   = r_count[IDX_W-1:0];
    assign cur_active = r_valid[r_idx] && (cur_link == LS_DETECTED || cur_link == LS_VLAN);
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat.command  = r_command;
        o_stat.full     = (r_count == CNT_W'(MAX_PEERS));
        o_stat.hit      = r_valid[r_idx] && (cur_addr == r_mac);
        o_stat.active   = cur_active;
        // countdown of zero or one runs out on this tick
        o_stat.expire   = cur_active && (cur_ticks[TICK_W-1:1] == '0);
        o_stat.last_idx = (r_idx == IDX_W'(MAX_PEERS - 1));
        o_stat.out_free = out_free;
    end

    // result formation
    always_comb begin
        n_status      = ST_TICK_DONE;
        n_peer_mac    = '0;
        n_entry_index = '0;
        n_last        = 1'b1;
        case (i_cmd.emit)
            EM_ADD: begin
                n_status      = ST_OK;
                n_peer_mac    = r_mac;
                n_entry_index = IDX_OUT_W'(add_slot);
            end
            EM_FULL: begin
                n_status   = ST_FULL;
                n_peer_mac = r_mac;
            end
            EM_CLEAR: begin
                n_status = ST_OK;
            end
            EM_EVENT_OK: begin
                n_status      = ST_OK;
                n_peer_mac    = r_mac;
                n_entry_index = IDX_OUT_W'(r_idx);
            end
            EM_NOT_FOUND: begin
                n_status   = ST_NOT_FOUND;
                n_peer_mac = r_mac;
            end
            EM_TIMEOUT: begin
                n_status      = ST_TIMED_OUT;
                n_peer_mac    = cur_addr;
                n_entry_index = IDX_OUT_W'(r_idx);
                n_last        = 1'b0;
            end
            default: begin
                n_status = ST_TICK_DONE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_idx       <= '0;
            r_count     <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_timeout <= i_cfg_wdata;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            case (i_cmd.wr)
                WR_ADD: begin
                    r_valid[add_slot] <= 1'b1;
                    r_count           <= r_count + 1'b1;
                end
                WR_CLEAR: begin
                    r_valid <= '0;
                    r_count <= '0;
                end
                default: ;
            endcase
            if (i_cmd.emit_en) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: captured item, table contents, output fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= t_cmd'(i_command);
            r_mac     <= i_mac;
            r_event   <= t_event'(i_event_code);
        end
        case (i_cmd.wr)
            WR_ADD: begin
                r_addr[add_slot]  <= r_mac;
                r_link[add_slot]  <= LS_DISCONNECTED;
                r_ticks[add_slot] <= '0;
            end
            WR_EVENT: begin
                case (r_event)
                    EV_PRIVATE_ACK: begin
                        r_link[r_idx]  <= LS_DETECTED;
                        r_ticks[r_idx] <= r_timeout;
                    end
                    EV_VLAN_ACK: begin
                        r_link[r_idx]  <= LS_VLAN;
                        r_ticks[r_idx] <= r_timeout;
                    end
                    EV_BACKHAUL_ACK: begin
                        r_link[r_idx]  <= LS_CONNECTED;
                        r_ticks[r_idx] <= '0;
                    end
                    default: begin
                        r_link[r_idx]  <= LS_DISCONNECTED;
                        r_ticks[r_idx] <= '0;
                    end
                endcase
            end
            WR_EXPIRE: begin
                r_link[r_idx]  <= LS_DISCONNECTED;
                r_ticks[r_idx] <= '0;
            end
            WR_DEC: begin
                r_ticks[r_idx] <= cur_ticks - 1'b1;
            end
            default: ;
        endcase
        if (i_cmd.emit_en) begin
            r_status      <= n_status;
            r_peer_mac    <= n_peer_mac;
            r_entry_index <= n_entry_index;
            r_last        <= n_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_peer_mac    = r_peer_mac;
    assign o_entry_index = r_entry_index;
    assign o_last        = r_last;

endmodule

FILE: hdl/peer_connection_timeout_table.sv
// ----------------------------------------------------------------------------
// peer_connection_timeout_table: peer link-state table with tick timeouts
// Peers keyed by MAC, each with a four-state link machine and a millisecond
// countdown; add, clear, event and tick commands.
//
//   channel   direction  handshake             contents
//   s_axis    in         tvalid/tready         tuser command, tdata mac+event
//   m_axis    out        tvalid/tready/tlast   tuser status, tdata mac+slot
//   cfg       in         i_cfg_wen             timeout_ticks
//
// Add and clear finish in the dispatch state; an event walks the table one
// slot per cycle, save for output stalls, to its first match; a tick walks all.
// Input is taken only between items; the output register lets the next
// item in while the last result waits. A stalled output holds the walk on
// the slot that has a result to give. Reset empties the table and loads
// the timeout with 60000.
// ----------------------------------------------------------------------------
module peer_connection_timeout_table #(
    parameter int MAX_PEERS = pctt_pkg::MAX_PEERS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wen,
    input  logic [pctt_pkg::TICK_W-1:0]      i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [47:0] mac, [49:48] event_code, [55:50] zero
    input  logic [pctt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] command
    input  logic [pctt_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [47:0] peer_mac, [51:48] entry_index, [55:52] zero
    output logic [pctt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // [2:0] status
    output logic [pctt_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                             m_axis_tlast
);
    import pctt_pkg::*;

    t_dp_cmd              dp_cmd;
    t_dp_stat             dp_stat;
    logic [STATUS_W-1:0]  out_status;
    logic [MAC_W-1:0]     out_mac;
    logic [IDX_OUT_W-1:0] out_index;

    pctt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    pctt_dp #(
        .MAX_PEERS (MAX_PEERS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_command     (s_axis_tuser),
        .i_mac         (s_axis_tdata[MAC_W-1:0]),
        .i_event_code  (s_axis_tdata[MAC_W+EV_W-1:MAC_W]),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (out_status),
        .o_peer_mac    (out_mac),
        .o_entry_index (out_index),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_index, out_mac};
    assign m_axis_tuser = out_status;

endmodule
